// ===== rtl/pcm_voice_mixer_top_assert.svh =====
// Assertion macros shared by the mixer RTL.
`ifndef PCM_VOICE_MIXER_TOP_ASSERT_SVH
`define PCM_VOICE_MIXER_TOP_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define PVM_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after its antecedent.
`define PVM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/pvm_pkg.sv =====
// ----------------------------------------------------------------------------
// pvm_pkg
// Constants, codes and the command/status types of the PCM voice mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package pvm_pkg;
  localparam int MaxVoices    = 16;
  localparam int MaxSounds    = 64;
  localparam int SampleDepth  = 65536;
  localparam int FracBits     = 16;
  localparam int VoiceW       = $clog2(MaxVoices);
  localparam int SoundW       = 6;
  localparam int AddrW        = $clog2(SampleDepth);
  localparam int FillW        = AddrW + 1;
  localparam int CountW       = $clog2(MaxSounds + 1);
  localparam int StepW        = 20;
  localparam int PosW         = FillW + FracBits;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_PLAY   = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_LOAD   = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_VOICE = 3'd1;
  localparam logic [2:0] ST_UNKNOWN  = 3'd2;
  localparam logic [2:0] ST_MEM_FULL = 3'd3;
  localparam logic [2:0] ST_TAB_FULL = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                capture;   // latch the input item
    logic                do_stop;
    logic                do_load;
    logic                do_finish;
    logic                play_scan; // compare slot against request
    logic                play_commit;
    logic                set_step;  // store the step of a freshly started voice
    logic                rd_voice;  // table data back, issue the sample read
    logic                mix_voice; // add sample and update voice
    logic [VoiceW-1:0]   slot;
    logic                clr_result;
  } pvm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       known;     // play id below sound count
    logic       hit_found; // an active voice holds the id
    logic       free_found;
    logic       slot_active;
  } pvm_sts_t;
endpackage
`default_nettype wire

// ===== rtl/pvm_ram.sv =====
// ----------------------------------------------------------------------------
// pvm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pvm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/pvm_datapath.sv =====
// ----------------------------------------------------------------------------
// pvm_datapath
// Voice state, sound tables, sample memory and the saturating mix adder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pcm_voice_mixer_top_assert.svh"
module pvm_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pvm_pkg::pvm_cmd_t   cmd,
  output pvm_pkg::pvm_sts_t        sts,
  input  wire logic [2:0]          in_op,
  input  wire logic signed [15:0]  in_music_left,
  input  wire logic signed [15:0]  in_music_right,
  input  wire logic [5:0]          in_sound_id,
  input  wire logic [15:0]         in_loop_count,
  input  wire logic [7:0]          in_sample_byte,
  input  wire logic [19:0]         in_sound_step,
  output logic signed [15:0]       res_left,
  output logic signed [15:0]       res_right,
  output logic [5:0]               res_id,
  output logic [2:0]               res_status
);
  localparam int VW = pvm_pkg::VoiceW;
  localparam int NV = pvm_pkg::MaxVoices;

  logic [2:0]  op_r;
  logic [5:0]  id_r;
  logic [15:0] loops_r;
  logic [7:0]  byte_r;
  logic [19:0] step_r;

  logic [pvm_pkg::FillW-1:0]  fill_r;
  logic [pvm_pkg::FillW-1:0]  pend_r;
  logic [pvm_pkg::CountW-1:0] count_r;

  logic                        act_r   [NV];
  logic [5:0]                  vsnd_r  [NV];
  logic [pvm_pkg::PosW-1:0]    vpos_r  [NV];
  logic [19:0]                 vstep_r [NV];
  logic [15:0]                 vloop_r [NV];

  logic          hit_r, free_r;
  logic [VW-1:0] hit_slot_r, free_slot_r;

  logic signed [15:0] acc_l_r, acc_r_r;

  // Sound tables and sample memory.
  logic [pvm_pkg::AddrW-1:0] st_rd;
  logic [pvm_pkg::FillW-1:0] ln_rd;
  logic [19:0]               sp_rd;
  logic [7:0]                smp_rd;
  logic [5:0]                tab_raddr;
  logic [pvm_pkg::AddrW-1:0] mem_raddr;
  logic                      tab_we;
  logic [pvm_pkg::FillW-1:0] len_w;

  // Per-voice read stage: the sound id is issued first, its table entries
  // come back, then the sample address is issued.
  logic [pvm_pkg::FillW-1:0] len_q;
  logic                      in_range_q;

  assign tab_we    = cmd.do_finish && (count_r < pvm_pkg::CountW'(pvm_pkg::MaxSounds));
  assign len_w     = fill_r - pend_r;
  assign tab_raddr = cmd.play_commit ? id_r : vsnd_r[cmd.slot];

  pvm_ram #(.Width(pvm_pkg::AddrW), .Depth(pvm_pkg::MaxSounds)) u_start (
    .clk, .we(tab_we), .waddr(count_r[5:0]), .wdata(pend_r[pvm_pkg::AddrW-1:0]),
    .raddr(tab_raddr), .rdata(st_rd));
  pvm_ram #(.Width(pvm_pkg::FillW), .Depth(pvm_pkg::MaxSounds)) u_len (
    .clk, .we(tab_we), .waddr(count_r[5:0]), .wdata(len_w),
    .raddr(tab_raddr), .rdata(ln_rd));
  pvm_ram #(.Width(20), .Depth(pvm_pkg::MaxSounds)) u_step (
    .clk, .we(tab_we), .waddr(count_r[5:0]), .wdata(step_r),
    .raddr(tab_raddr), .rdata(sp_rd));

  logic [pvm_pkg::FillW-1:0] idx_w;
  logic [pvm_pkg::FillW:0]   addr_sum;
  assign idx_w    = vpos_r[cmd.slot][pvm_pkg::PosW-1:pvm_pkg::FracBits];
  assign addr_sum = {2'b00, st_rd} + {1'b0, idx_w};
  assign mem_raddr = addr_sum[pvm_pkg::AddrW-1:0];

  pvm_ram #(.Width(8), .Depth(pvm_pkg::SampleDepth)) u_smp (
    .clk, .we(cmd.do_load && !fill_r[pvm_pkg::AddrW]),
    .waddr(fill_r[pvm_pkg::AddrW-1:0]), .wdata(byte_r),
    .raddr(mem_raddr), .rdata(smp_rd));

  // Saturating adds.
  logic signed [16:0] smp_v, sum_l, sum_r;
  logic signed [15:0] sat_l, sat_r;
  assign smp_v = 17'(signed'({1'b0, smp_rd}) - 17'sd128) <<< 7;
  assign sum_l = 17'(acc_l_r) + smp_v;
  assign sum_r = 17'(acc_r_r) + smp_v;
  always_comb begin
    sat_l = sum_l[15:0];
    sat_r = sum_r[15:0];
    if (sum_l > 17'sd32767)  sat_l = 16'sh7fff;
    if (sum_l < -17'sd32768) sat_l = 16'sh8000;
    if (sum_r > 17'sd32767)  sat_r = 16'sh7fff;
    if (sum_r < -17'sd32768) sat_r = 16'sh8000;
  end

  logic [pvm_pkg::PosW-1:0] pos_adv;
  logic                     at_end;
  assign pos_adv = vpos_r[cmd.slot] + pvm_pkg::PosW'(vstep_r[cmd.slot]);
  assign at_end  = pos_adv >= {len_q, pvm_pkg::FracBits'(0)};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      id_r    <= in_sound_id;
      loops_r <= in_loop_count;
      byte_r  <= in_sample_byte;
      step_r  <= in_sound_step;
      acc_l_r <= in_music_left;
      acc_r_r <= in_music_right;
    end
    if (cmd.rd_voice) begin
      len_q      <= ln_rd;
      in_range_q <= act_r[cmd.slot] && ({1'b0, idx_w} < {1'b0, ln_rd})
                    && (addr_sum[pvm_pkg::FillW:pvm_pkg::AddrW] == 2'b00);
    end
    if (cmd.mix_voice && in_range_q) begin
      acc_l_r <= sat_l;
      acc_r_r <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      pend_r   <= '0;
      count_r  <= '0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      hit_slot_r  <= '0;
      free_slot_r <= '0;
      res_left <= '0;
      res_right <= '0;
      res_id   <= '0;
      res_status <= pvm_pkg::ST_OK;
      for (int i = 0; i < NV; i++) begin
        act_r[i]   <= 1'b0;
        vsnd_r[i]  <= '0;
        vpos_r[i]  <= '0;
        vstep_r[i] <= '0;
        vloop_r[i] <= '0;
      end
    end else begin
      if (cmd.clr_result) begin
        res_left   <= '0;
        res_right  <= '0;
        res_id     <= '0;
        res_status <= pvm_pkg::ST_OK;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end
      if (cmd.do_stop) begin
        for (int i = 0; i < NV; i++) act_r[i] <= 1'b0;
      end
      if (cmd.do_load) begin
        if (fill_r[pvm_pkg::AddrW]) res_status <= pvm_pkg::ST_MEM_FULL;
        else fill_r <= fill_r + 1'b1;
      end
      if (cmd.do_finish) begin
        if (tab_we) begin
          res_id  <= count_r[5:0];
          count_r <= count_r + 1'b1;
          pend_r  <= fill_r;
        end else begin
          res_status <= pvm_pkg::ST_TAB_FULL;
        end
      end
      if (cmd.play_scan) begin
        if (act_r[cmd.slot] && vsnd_r[cmd.slot] == id_r && !hit_r) begin
          hit_r      <= 1'b1;
          hit_slot_r <= cmd.slot;
        end
        if (!act_r[cmd.slot] && !free_r) begin
          free_r      <= 1'b1;
          free_slot_r <= cmd.slot;
        end
      end
      if (cmd.play_commit) begin
        if ({1'b0, id_r} >= pvm_pkg::CountW'(count_r)) begin
          res_status <= pvm_pkg::ST_UNKNOWN;
        end else if (hit_r) begin
          vpos_r[hit_slot_r]  <= '0;
          vloop_r[hit_slot_r] <= loops_r;
        end else if (free_r) begin
          act_r[free_slot_r]   <= 1'b1;
          vsnd_r[free_slot_r]  <= id_r;
          vpos_r[free_slot_r]  <= '0;
          vloop_r[free_slot_r] <= loops_r;
        end else begin
          res_status <= pvm_pkg::ST_NO_VOICE;
        end
      end
      // Step table read lands in the cycle after commit for a fresh voice.
      if (cmd.set_step && free_r && !hit_r
          && ({1'b0, id_r} < pvm_pkg::CountW'(count_r))) begin
        vstep_r[free_slot_r] <= sp_rd;
      end
      if (cmd.mix_voice && act_r[cmd.slot]) begin
        if ({1'b0, vsnd_r[cmd.slot]} >= pvm_pkg::CountW'(count_r)) begin
          act_r[cmd.slot] <= 1'b0;
        end else if (at_end) begin
          if (vloop_r[cmd.slot] != 16'd0) begin
            vloop_r[cmd.slot] <= vloop_r[cmd.slot] - 16'd1;
            vpos_r[cmd.slot]  <= '0;
          end else begin
            act_r[cmd.slot] <= 1'b0;
            vpos_r[cmd.slot] <= pos_adv;
          end
        end else begin
          vpos_r[cmd.slot] <= pos_adv;
        end
      end
      if (op_r == pvm_pkg::OP_TICK && cmd.rd_voice == 1'b0 && cmd.mix_voice == 1'b0
          && cmd.play_scan == 1'b0 && cmd.capture == 1'b0 && cmd.clr_result == 1'b0
          && cmd.do_stop == 1'b0 && cmd.play_commit == 1'b0) begin
        res_left  <= acc_l_r;
        res_right <= acc_r_r;
      end
    end
  end

  assign sts.op          = op_r;
  assign sts.known       = {1'b0, id_r} < pvm_pkg::CountW'(count_r);
  assign sts.hit_found   = hit_r;
  assign sts.free_found  = free_r;
  assign sts.slot_active = act_r[cmd.slot];

  `PVM_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1,
    fill_r <= pvm_pkg::FillW'(pvm_pkg::SampleDepth), "fill pointer beyond memory")
  `PVM_ASSERT_IMPL(a_pend_le_fill, clk, rst_n, 1'b1, pend_r <= fill_r,
    "open sound start beyond fill pointer")
  `PVM_ASSERT_NEXT(a_count_step, clk, rst_n, !cmd.do_finish,
    count_r == $past(count_r), "sound count moved without a finish")
endmodule
`default_nettype wire

// ===== rtl/pvm_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvm_ctrl
// Sequencer: takes an item, runs the mix pass over the voices, the play scan or the
// stop, load or finish update, then presents the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pcm_voice_mixer_top_assert.svh"
module pvm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pvm_pkg::pvm_cmd_t      cmd,
  input  wire pvm_pkg::pvm_sts_t sts
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MIX   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_FRESH = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_ADDR  = 4'd8;

  localparam int VW = pvm_pkg::VoiceW;

  logic [3:0]    state_r, state_nxt;
  logic [VW-1:0] slot_r, slot_nxt;
  logic          last_slot;

  assign last_slot = slot_r == VW'(pvm_pkg::MaxVoices - 1);
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    cmd       = '0;
    cmd.slot  = slot_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        cmd.clr_result = 1'b1;
        slot_nxt = '0;
        unique case (sts.op)
          pvm_pkg::OP_TICK:   state_nxt = S_RD;
          pvm_pkg::OP_PLAY:   state_nxt = S_SCAN;
          pvm_pkg::OP_STOP:   begin cmd.do_stop = 1'b0; state_nxt = S_DONE; end
          pvm_pkg::OP_LOAD:   state_nxt = S_DONE;
          pvm_pkg::OP_FINISH: state_nxt = S_DONE;
          default:            state_nxt = S_OUT;
        endcase
      end
      S_RD: begin
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.rd_voice = 1'b1;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix_voice = 1'b1;
        if (last_slot) state_nxt = S_DONE;
        else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_SCAN: begin
        cmd.play_scan = 1'b1;
        if (last_slot) state_nxt = S_DONE;
        else slot_nxt = slot_r + 1'b1;
      end
      S_FRESH: begin
        cmd.set_step = 1'b1;
        state_nxt = S_OUT;
      end
      S_DONE: begin
        unique case (sts.op)
          pvm_pkg::OP_STOP:   cmd.do_stop = 1'b1;
          pvm_pkg::OP_LOAD:   cmd.do_load = 1'b1;
          pvm_pkg::OP_FINISH: cmd.do_finish = 1'b1;
          pvm_pkg::OP_PLAY:   cmd.play_commit = 1'b1;
          default:            cmd.do_stop = 1'b0;
        endcase
        if (sts.op == pvm_pkg::OP_PLAY) begin
          cmd.slot  = '0;
          state_nxt = S_FRESH;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  `PVM_ASSERT_IMPL(a_one_cmd, clk, rst_n, 1'b1,
    $onehot0({cmd.do_stop, cmd.do_load, cmd.do_finish, cmd.play_commit, cmd.mix_voice}),
    "more than one datapath command")
  `PVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
    "result withdrawn while stalled")
  `PVM_ASSERT_IMPL(a_no_take_busy, clk, rst_n, cmd.capture, state_r == S_IDLE,
    "item captured while busy")
endmodule
`default_nettype wire

// ===== rtl/pcm_voice_mixer_top.sv =====
// Sequence: a tick runs dispatch, then for each voice slot a table read, a sample read
// and a mix, then a closing step before its result is offered; play runs dispatch, a scan
// of every voice slot, commit and step load; stop, load and finish run dispatch, then their update.
// Throughput: one item at a time; the next input transfer is taken only after the result
// transfer, once the sequencer is back in idle.
// Reset (synchronous, rst_n low) frees all voices and clears the fill pointer and count.
// ----------------------------------------------------------------------------
// pcm_voice_mixer_top
// Multi-voice PCM sound-effect mixer: a sequencer drives a datapath holding
// the voice slots, sound tables and sample memory.
// ----------------------------------------------------------------------------
`default_nettype none
module pcm_voice_mixer_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [15:0] in_music_left,
  input  wire logic signed [15:0] in_music_right,
  input  wire logic [5:0]         in_sound_id,
  input  wire logic [15:0]        in_loop_count,
  input  wire logic [7:0]         in_sample_byte,
  input  wire logic [19:0]        in_sound_step,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_left,
  output logic signed [15:0]      out_right,
  output logic [5:0]              out_new_sound_id,
  output logic [2:0]              out_status
);
  pvm_pkg::pvm_cmd_t cmd;
  pvm_pkg::pvm_sts_t sts;

  // The sequencer owns the handshakes; the datapath only sees commands.
  pvm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts);

  // The result registers hold steady through the output transfer.
  pvm_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_op, .in_music_left, .in_music_right,
    .in_sound_id, .in_loop_count, .in_sample_byte, .in_sound_step,
    .res_left(out_left), .res_right(out_right), .res_id(out_new_sound_id),
    .res_status(out_status));
endmodule
`default_nettype wire
